// ----- design/assert_macros.svh -----
// Assertion macros used by the segment run allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed")
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed")
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/sra_pkg.sv -----
// Constants and codes of the segment run allocator.
package sra_pkg;

   localparam int SEGMENTS = 256;
   localparam int IDX_W    = $clog2(SEGMENTS);
   localparam int TAG_W    = $clog2(SEGMENTS + 1);
   localparam int SEG_W    = 25;
   localparam int ADDR_W   = 32;
   localparam int USED_W   = 9;
   localparam int ST_W     = 2;
   localparam int COV_W    = (TAG_W + SEG_W > ADDR_W + 1) ? TAG_W + SEG_W : ADDR_W + 1;
   localparam int PADDR_W  = 3;

   localparam logic [SEG_W-1:0]  SEG_SIZE_RESET = SEG_W'(4096);
   localparam logic [ADDR_W-1:0] BASE_RESET     = '0;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [ST_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [ST_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [ST_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic CSR_SEG_SIZE = 1'b0;
   localparam logic CSR_BASE     = 1'b1;

endpackage

// ----- design/segment_run_allocator.sv -----
// Top level of the first-fit segment run allocator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | req_valid/req_ready  | req_cmd, req_size_bytes, req_address
//  response | rsp_valid/rsp_ready  | rsp_status, rsp_result_address,
//           |                      |    rsp_used_segments
//  csr      | psel/penable/pready  | pwrite, paddr, pwdata, prdata
//
// Allocate: table reads run to the end of the first fitting run (index F), then
// one write per segment of the run marks it, and S_FINISH sends the response.
// The scan reads one table entry per cycle.
// Free: the scan reads up to the run's start at index S, then clears its L segments.
// Reset clears all per-entry valid bits together; no clearing pass follows.
// One request is in work at a time; a new one is taken while a result waits.
module segment_run_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [sra_pkg::ADDR_W-1:0]        req_size_bytes,
   input  logic [sra_pkg::ADDR_W-1:0]        req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sra_pkg::ST_W-1:0]          rsp_status,
   output logic [sra_pkg::ADDR_W-1:0]        rsp_result_address,
   output logic [sra_pkg::USED_W-1:0]        rsp_used_segments,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sra_pkg::PADDR_W-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CLEAR, S_MARK, S_FINISH} state_type;

   localparam logic [sra_pkg::IDX_W-1:0] LAST_IDX = sra_pkg::IDX_W'(sra_pkg::SEGMENTS - 1);

   state_type                        state_ff, state_in;
   logic [sra_pkg::SEG_W-1:0]        seg_size_ff;
   logic [sra_pkg::ADDR_W-1:0]       base_ff;

   logic                             cmd_ff, cmd_in;
   logic [sra_pkg::ADDR_W-1:0]       size_ff, size_in;
   logic [sra_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [sra_pkg::TAG_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [sra_pkg::IDX_W-1:0]        chk_ff, chk_in;
   logic                             pend_ff, pend_in;
   logic [sra_pkg::TAG_W-1:0]        run_ff, run_in;
   logic [sra_pkg::COV_W-1:0]        cover_ff, cover_in;
   logic [sra_pkg::IDX_W-1:0]        first_ff, first_in;
   logic [sra_pkg::IDX_W-1:0]        mark_ff, mark_in;
   logic [sra_pkg::IDX_W-1:0]        last_ff, last_in;
   logic [sra_pkg::TAG_W-1:0]        cur_tag_ff, cur_tag_in;
   logic [sra_pkg::TAG_W-1:0]        used_ff, used_in;
   logic [sra_pkg::ST_W-1:0]         res_status_ff, res_status_in;
   logic [sra_pkg::ADDR_W-1:0]       res_addr_ff, res_addr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sra_pkg::ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [sra_pkg::ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [sra_pkg::USED_W-1:0]       rsp_used_ff, rsp_used_in;

   // Owner memory with one valid bit per entry; an entry not yet written reads as free.
   logic [sra_pkg::TAG_W-1:0]        owner_mem_ff [sra_pkg::SEGMENTS];
   logic [sra_pkg::SEGMENTS-1:0]     valid_ff;
   logic [sra_pkg::TAG_W-1:0]        owner_q_ff;
   logic                             valid_q_ff;

   logic                             rd_en;
   logic [sra_pkg::IDX_W-1:0]        rd_addr;
   logic                             wr_en;
   logic [sra_pkg::IDX_W-1:0]        wr_addr;
   logic [sra_pkg::TAG_W-1:0]        wr_data;

   logic [sra_pkg::TAG_W-1:0]        tag;
   logic [sra_pkg::SEG_W-1:0]        seg_bytes;
   logic [sra_pkg::IDX_W-1:0]        mul_idx;
   logic [sra_pkg::IDX_W+sra_pkg::SEG_W-1:0] prod;
   logic [sra_pkg::ADDR_W-1:0]       start_addr;
   logic [sra_pkg::COV_W-1:0]        cover_new;
   logic                             csr_wr;

   assign tag        = valid_q_ff ? owner_q_ff : '0;
   assign seg_bytes  = (seg_size_ff == '0) ? sra_pkg::SEG_W'(1) : seg_size_ff;
   assign prod       = mul_idx * seg_bytes;
   assign start_addr = base_ff + sra_pkg::ADDR_W'(prod);
   assign cover_new  = cover_ff + sra_pkg::COV_W'(seg_bytes);

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_used_segments  = rsp_used_ff;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         sra_pkg::CSR_SEG_SIZE: prdata = 32'(seg_size_ff);
         sra_pkg::CSR_BASE:     prdata = base_ff;
         default:               prdata = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      rd_idx_in     = rd_idx_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      run_in        = run_ff;
      cover_in      = cover_ff;
      first_in      = first_ff;
      mark_in       = mark_ff;
      last_in       = last_ff;
      cur_tag_in    = cur_tag_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[sra_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = chk_ff;
      wr_data       = '0;
      mul_idx       = sra_pkg::IDX_W'(tag - sra_pkg::TAG_W'(1));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Scan and clear keep one table read in flight each cycle.
      if ((state_ff == S_SCAN) || (state_ff == S_CLEAR)) begin
         if (rd_idx_ff < sra_pkg::TAG_W'(sra_pkg::SEGMENTS)) begin
            rd_en     = 1'b1;
            rd_idx_in = rd_idx_ff + sra_pkg::TAG_W'(1);
            chk_in    = rd_idx_ff[sra_pkg::IDX_W-1:0];
            pend_in   = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               size_in   = req_size_bytes;
               addr_in   = req_address;
               rd_idx_in = '0;
               run_in    = '0;
               cover_in  = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_ff) begin
               if (cmd_ff == sra_pkg::CMD_ALLOC) begin
                  if (tag != '0) begin
                     run_in   = '0;
                     cover_in = '0;
                     if (chk_ff == LAST_IDX) begin
                        res_status_in = sra_pkg::STATUS_NO_SPACE;
                        res_addr_in   = '0;
                        state_in      = S_FINISH;
                     end
                  end else begin
                     if (run_ff == '0) begin
                        first_in = chk_ff;
                     end
                     run_in   = run_ff + sra_pkg::TAG_W'(1);
                     cover_in = cover_new;
                     if (cover_new >= sra_pkg::COV_W'(size_ff)) begin
                        mark_in  = (run_ff == '0) ? chk_ff : first_ff;
                        last_in  = chk_ff;
                        state_in = S_MARK;
                     end else if (chk_ff == LAST_IDX) begin
                        res_status_in = sra_pkg::STATUS_NO_SPACE;
                        res_addr_in   = '0;
                        state_in      = S_FINISH;
                     end
                  end
               end else begin
                  if ((tag != '0) && (start_addr == addr_ff)) begin
                     wr_en         = 1'b1;
                     used_in       = used_ff - sra_pkg::TAG_W'(1);
                     cur_tag_in    = tag;
                     res_status_in = sra_pkg::STATUS_OK;
                     res_addr_in   = addr_ff;
                     state_in      = (chk_ff == LAST_IDX) ? S_FINISH : S_CLEAR;
                  end else if (chk_ff == LAST_IDX) begin
                     res_status_in = sra_pkg::STATUS_NOT_FOUND;
                     res_addr_in   = '0;
                     state_in      = S_FINISH;
                  end
               end
            end
         end
         S_CLEAR: begin
            if (pend_ff) begin
               if (tag == cur_tag_ff) begin
                  wr_en   = 1'b1;
                  used_in = used_ff - sra_pkg::TAG_W'(1);
                  if (chk_ff == LAST_IDX) begin
                     state_in = S_FINISH;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_MARK: begin
            mul_idx     = first_ff;
            wr_en       = 1'b1;
            wr_addr     = mark_ff;
            wr_data     = sra_pkg::TAG_W'(first_ff) + sra_pkg::TAG_W'(1);
            res_addr_in = start_addr;
            if (mark_ff == last_ff) begin
               used_in       = used_ff + run_ff;
               res_status_in = sra_pkg::STATUS_OK;
               state_in      = S_FINISH;
            end else begin
               mark_in = mark_ff + sra_pkg::IDX_W'(1);
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_used_in   = sra_pkg::USED_W'(used_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         valid_ff     <= '0;
         seg_size_ff  <= sra_pkg::SEG_SIZE_RESET;
         base_ff      <= sra_pkg::BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_wr && (paddr[2] == sra_pkg::CSR_SEG_SIZE)) begin
            seg_size_ff <= pwdata[sra_pkg::SEG_W-1:0];
         end
         if (csr_wr && (paddr[2] == sra_pkg::CSR_BASE)) begin
            base_ff <= pwdata;
         end
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      chk_ff        <= chk_in;
      run_ff        <= run_in;
      cover_ff      <= cover_in;
      first_ff      <= first_in;
      mark_ff       <= mark_in;
      last_ff       <= last_in;
      cur_tag_ff    <= cur_tag_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         owner_q_ff <= owner_mem_ff[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
      end
   end

   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= sra_pkg::TAG_W'(sra_pkg::SEGMENTS));
   `ASSERT_ALWAYS(a_mark_range, clock, reset, (state_ff != S_MARK) || (mark_ff <= last_ff));
   `ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_valid_ff || (rsp_status_ff != 2'd3));
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff == S_SCAN);
   `ASSERT_NEXT(a_fail_zero, clock, reset, (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready)
      && (res_status_ff != sra_pkg::STATUS_OK), rsp_addr_ff == '0);

endmodule
